@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the delta varint list decoder RTL.
// Depends on nothing; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define DVLD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define DVLD_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/dvld_pkg.sv @@
// Shared constants and types for the delta varint list decoder.
// Used by dvld_decode and delta_varint_list_decoder_core; depends on nothing.
package dvld_pkg;

    localparam int unsigned COUNT_HEADER_BYTES = 8;
    localparam int unsigned BYTE_W             = 8;
    localparam int unsigned VALUE_W            = 64;
    localparam int unsigned HDR_CNT_W          = 4;
    localparam int unsigned SHIFT_W            = 7;
    localparam int unsigned GROUP_BITS         = 7;
    localparam int unsigned CONT_BIT           = 7;
    localparam int unsigned FLAGS_W            = 3;

    localparam logic [HDR_CNT_W-1:0] HDR_BYTES   = HDR_CNT_W'(COUNT_HEADER_BYTES);
    localparam logic [SHIFT_W-1:0]   SHIFT_LIMIT = SHIFT_W'(VALUE_W);
    localparam logic [SHIFT_W-1:0]   SHIFT_STEP  = SHIFT_W'(GROUP_BITS);

    // Bit positions of the flags in the result tuser.
    localparam int unsigned FLAG_VALUE_VALID  = 0;
    localparam int unsigned FLAG_LIST_DONE    = 1;
    localparam int unsigned FLAG_SHORT_STREAM = 2;

    typedef struct packed {
        logic               value_valid;
        logic [VALUE_W-1:0] value;
        logic               list_done;
        logic               buffer_end;
        logic               short_stream;
    } dvld_result_t;

endpackage

@@ hw/rtl/dvld_decode.sv @@
// Decode state and single-byte update logic of the delta varint list decoder.
// Depends on dvld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dvld_decode (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  logic [dvld_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           last_byte,
    output dvld_pkg::dvld_result_t         result
);

    logic [dvld_pkg::HDR_CNT_W-1:0] hdr_seen_reg,  hdr_seen_next;
    logic [dvld_pkg::VALUE_W-1:0]   count_reg,     count_next;
    logic [dvld_pkg::VALUE_W-1:0]   decoded_reg,   decoded_next;
    logic [dvld_pkg::VALUE_W-1:0]   acc_reg,       acc_next;
    logic [dvld_pkg::SHIFT_W-1:0]   shift_reg,     shift_next;
    logic [dvld_pkg::VALUE_W-1:0]   prev_reg,      prev_next;

    logic                           hdr_phase;
    logic                           list_active;
    logic                           shift_ok;
    logic                           complete;
    logic [dvld_pkg::VALUE_W-1:0]   hdr_byte_shifted;
    logic [dvld_pkg::VALUE_W-1:0]   payload_shifted;
    logic [dvld_pkg::VALUE_W-1:0]   acc_upd;
    logic [dvld_pkg::SHIFT_W-1:0]   shift_upd;
    logic [dvld_pkg::VALUE_W-1:0]   sum;
    logic [dvld_pkg::VALUE_W-1:0]   decoded_inc;
    logic [dvld_pkg::VALUE_W-1:0]   count_upd;
    logic [dvld_pkg::HDR_CNT_W-1:0] hdr_seen_upd;
    logic [dvld_pkg::VALUE_W-1:0]   decoded_upd;

    assign hdr_phase   = hdr_seen_reg < dvld_pkg::HDR_BYTES;
    assign list_active = decoded_reg < count_reg;
    assign shift_ok    = shift_reg < dvld_pkg::SHIFT_LIMIT;

    // Header bytes land little-endian; the byte slot is the low three bits of the count.
    assign hdr_byte_shifted = dvld_pkg::VALUE_W'(data_byte) << {hdr_seen_reg[2:0], 3'b000};

    // Below the limit the shift is under 64, so its low six bits are the whole amount.
    assign payload_shifted = dvld_pkg::VALUE_W'(data_byte[dvld_pkg::GROUP_BITS-1:0])
                             << shift_reg[5:0];
    assign acc_upd   = shift_ok ? (acc_reg | payload_shifted) : acc_reg;
    assign shift_upd = shift_ok ? (shift_reg + dvld_pkg::SHIFT_STEP) : shift_reg;

    // A varint cut off by the end of the buffer still completes a value.
    assign complete = !hdr_phase && list_active &&
                      (!data_byte[dvld_pkg::CONT_BIT] || last_byte);

    assign sum          = prev_reg + acc_upd;
    assign decoded_inc  = decoded_reg + dvld_pkg::VALUE_W'(1);
    assign count_upd    = hdr_phase ? (count_reg | hdr_byte_shifted) : count_reg;
    assign hdr_seen_upd = hdr_phase ? (hdr_seen_reg + dvld_pkg::HDR_CNT_W'(1)) : hdr_seen_reg;
    assign decoded_upd  = complete ? decoded_inc : decoded_reg;

    always_comb begin
        result.value_valid  = complete;
        result.value        = complete ? sum : '0;
        result.list_done    = complete && (decoded_inc == count_reg);
        result.buffer_end   = last_byte;
        result.short_stream = last_byte &&
                              ((hdr_seen_upd < dvld_pkg::HDR_BYTES) || (decoded_upd < count_upd));
    end

    always_comb begin
        hdr_seen_next = hdr_seen_reg;
        count_next    = count_reg;
        decoded_next  = decoded_reg;
        acc_next      = acc_reg;
        shift_next    = shift_reg;
        prev_next     = prev_reg;
        if (step_en) begin
            if (last_byte) begin
                // The end of a buffer returns every piece of state to its reset value.
                hdr_seen_next = '0;
                count_next    = '0;
                decoded_next  = '0;
                acc_next      = '0;
                shift_next    = '0;
                prev_next     = '0;
            end else if (hdr_phase) begin
                hdr_seen_next = hdr_seen_upd;
                count_next    = count_upd;
            end else if (list_active) begin
                if (complete) begin
                    decoded_next = decoded_inc;
                    prev_next    = sum;
                    acc_next     = '0;
                    shift_next   = '0;
                end else begin
                    acc_next   = acc_upd;
                    shift_next = shift_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_seen_reg <= '0;
            count_reg    <= '0;
            decoded_reg  <= '0;
            acc_reg      <= '0;
            shift_reg    <= '0;
            prev_reg     <= '0;
        end else begin
            hdr_seen_reg <= hdr_seen_next;
            count_reg    <= count_next;
            decoded_reg  <= decoded_next;
            acc_reg      <= acc_next;
            shift_reg    <= shift_next;
            prev_reg     <= prev_next;
        end
    end

    `DVLD_ASSERT(a_clear_after_end, aclk, aresetn, (step_en && last_byte) |=> (hdr_seen_reg == '0 && decoded_reg == '0 && shift_reg == '0), "state not cleared after buffer end")
    `DVLD_NEVER(a_decoded_bound, aclk, aresetn, decoded_reg > count_reg, "more values decoded than counted")
    `DVLD_ASSERT(a_varint_restart, aclk, aresetn, (step_en && complete) |=> (shift_reg == '0 && acc_reg == '0), "varint not restarted after a value")

endmodule

@@ hw/rtl/delta_varint_list_decoder_core.sv @@
// Top level of the delta varint list decoder: input register, decode step and result register.
// Depends on dvld_pkg, dvld_decode and assert_macros.svh.
//
// The decoder takes one byte of an encoded buffer per transfer and returns exactly one result
// transfer for each byte, in order. It sustains one byte per clock cycle while m_tready holds
// high. A byte waits in the input register and is decoded on its way into the result
// register, which offers its result on m_tvalid. The decode step is a 64-bit add of the
// previous value and the delta plus a 64-bit compare of decoded values against the count.
// While the result side stalls, the input and result registers hold two bytes before
// s_tready drops, and s_tready follows m_tready in the same cycle.
// The first eight bytes of each buffer form a little-endian value count; after that each
// LEB128 varint is a delta added to the previous value. m_tuser flags whether a value was
// produced, whether it was the final one, and (with m_tlast) whether the buffer was short.
`include "assert_macros.svh"

module delta_varint_list_decoder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dvld_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dvld_pkg::VALUE_W-1:0]    m_tdata,   // [63:0] value
    output logic [dvld_pkg::FLAGS_W-1:0]    m_tuser,   // [0] value_valid, [1] list_done,
                                                       // [2] short_stream
    output logic                            m_tlast    // buffer_end
);

    logic                         in_valid_reg, in_valid_next;
    logic [dvld_pkg::BYTE_W-1:0]  in_data_reg,  in_data_next;
    logic                         in_last_reg,  in_last_next;
    logic                         out_valid_reg, out_valid_next;
    dvld_pkg::dvld_result_t       out_res_reg,   out_res_next;

    dvld_pkg::dvld_result_t       step_res;
    logic                         advance;
    logic                         s_xfer;

    // A byte moves into decode when the result register is free or is being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    dvld_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .result    (step_res)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        in_last_next   = in_last_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
            in_data_next  = s_tdata;
            in_last_next  = s_tlast;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_res_next   = step_res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        in_last_reg <= in_last_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.value;
    assign m_tlast  = out_res_reg.buffer_end;
    assign m_tuser[dvld_pkg::FLAG_VALUE_VALID]  = out_res_reg.value_valid;
    assign m_tuser[dvld_pkg::FLAG_LIST_DONE]    = out_res_reg.list_done;
    assign m_tuser[dvld_pkg::FLAG_SHORT_STREAM] = out_res_reg.short_stream;

    `DVLD_NEVER(a_done_needs_value, aclk, aresetn, out_valid_reg && out_res_reg.list_done && !out_res_reg.value_valid, "list done without a value")
    `DVLD_NEVER(a_short_needs_end, aclk, aresetn, out_valid_reg && out_res_reg.short_stream && !out_res_reg.buffer_end, "short flag outside buffer end")
    `DVLD_ASSERT(a_input_held, aclk, aresetn, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg) && $stable(in_last_reg)), "input register lost a waiting byte")

endmodule
